/* sv/sbcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_pkg
// shared constants, codes and types of the start-byte command deframer
// ----------------------------------------------------------------------------
package sbcd_pkg;

    localparam int FRAME_BYTES_DEF = 19;
    localparam int AXES_DEF        = 4;
    localparam int AXIS_SLOTS      = 4;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 5;
    localparam int AXIS_W    = 32;
    localparam int ACTION_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int SLOT_W    = 2;
    localparam int LANE_W    = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_STREAM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_RESET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_HOME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_OPEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_CLOSE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ESTOP  = 3'd6;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_CODE_STREAM = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CODE_RESET  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_CODE_HOME   = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CODE_OPEN   = 8'd4;
    localparam logic [BYTE_W-1:0] RST_CODE_CLOSE  = 8'd5;
    localparam logic [BYTE_W-1:0] RST_CODE_ESTOP  = 8'd6;

    // decoded actions
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STREAM  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_HOME    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_OPEN    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLOSE   = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_ESTOP   = 3'd6;

    typedef enum logic [1:0] {
        TOK_START = 2'd0,
        TOK_CMD   = 2'd1,
        TOK_DATA  = 2'd2,
        TOK_CHECK = 2'd3
    } tok_kind_t;

    // one classified byte between front and back
    typedef struct packed {
        tok_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic              store;
        logic [SLOT_W-1:0] slot;
        logic [LANE_W-1:0] lane;
    } tok_t;

    typedef struct packed {
        logic [BYTE_W-1:0] stream;
        logic [BYTE_W-1:0] rst;
        logic [BYTE_W-1:0] home;
        logic [BYTE_W-1:0] open;
        logic [BYTE_W-1:0] close;
        logic [BYTE_W-1:0] estop;
    } cmd_codes_t;

endpackage
`default_nettype wire

/* sv/sync_byte_command_deframer_top.sv */
`default_nettype none
// result: registered when its checksum beat is accepted; that beat waits
// only while an unaccepted result holds the back
// throughput: one rx beat per cycle, set by the two-entry queue and the result register
// a pending result does not stop intake; only a full queue behind it does
// reset (aresetn low, synchronous): hunting for start, queue empty, no result,
// command codes and start code back to their defaults
// ----------------------------------------------------------------------------
// sync_byte_command_deframer_top
// start-byte framed command receiver with xor checksum and command decode
// ----------------------------------------------------------------------------
module sync_byte_command_deframer_top #(
    parameter int FRAME_BYTES = sbcd_pkg::FRAME_BYTES_DEF,
    parameter int AXES        = sbcd_pkg::AXES_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // config write port
    input  wire                           cfg_we,
    input  wire  [sbcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [sbcd_pkg::BYTE_W-1:0]   cfg_wdata,
    // rx beats
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [sbcd_pkg::BYTE_W-1:0]   s_rx_byte,
    // decoded commands
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [sbcd_pkg::ACTION_W-1:0] m_action,
    output logic [sbcd_pkg::BYTE_W-1:0]   m_command_byte,
    output logic signed [sbcd_pkg::AXIS_W-1:0] m_axis_value_0,
    output logic signed [sbcd_pkg::AXIS_W-1:0] m_axis_value_1,
    output logic signed [sbcd_pkg::AXIS_W-1:0] m_axis_value_2,
    output logic signed [sbcd_pkg::AXIS_W-1:0] m_axis_value_3
);
    import sbcd_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] start_code_reg;
    cmd_codes_t        codes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg  <= RST_START_CODE;
            codes_reg.stream <= RST_CODE_STREAM;
            codes_reg.rst    <= RST_CODE_RESET;
            codes_reg.home   <= RST_CODE_HOME;
            codes_reg.open   <= RST_CODE_OPEN;
            codes_reg.close  <= RST_CODE_CLOSE;
            codes_reg.estop  <= RST_CODE_ESTOP;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_CODE:  start_code_reg   <= cfg_wdata;
                REG_CODE_STREAM: codes_reg.stream <= cfg_wdata;
                REG_CODE_RESET:  codes_reg.rst    <= cfg_wdata;
                REG_CODE_HOME:   codes_reg.home   <= cfg_wdata;
                REG_CODE_OPEN:   codes_reg.open   <= cfg_wdata;
                REG_CODE_CLOSE:  codes_reg.close  <= cfg_wdata;
                REG_CODE_ESTOP:  codes_reg.estop  <= cfg_wdata;
                default: begin
                    // indexes past the list are dropped
                end
            endcase
        end
    end

    // front to queue
    logic push_valid, push_ready;
    tok_t push_tok;
    // queue to back
    logic pop_valid, pop_ready;
    tok_t pop_tok;

    logic signed [AXIS_W-1:0] axis_value [AXIS_SLOTS];

    // front: start hunt and byte position tagging
    sbcd_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .AXES        (AXES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .start_code (start_code_reg),
        .push_valid (push_valid),
        .push_tok   (push_tok),
        .push_ready (push_ready)
    );

    // decoupling queue so intake runs while a result waits
    sbcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_tok    (push_tok),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_tok   (pop_tok)
    );

    // back: checksum, axis assembly, decode, result register
    sbcd_back #(
        .AXES (AXES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tok_valid      (pop_valid),
        .tok_ready      (pop_ready),
        .tok            (pop_tok),
        .codes          (codes_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_command_byte (m_command_byte),
        .m_axis_value   (axis_value)
    );

    assign m_axis_value_0 = axis_value[0];
    assign m_axis_value_1 = axis_value[1];
    assign m_axis_value_2 = axis_value[2];
    assign m_axis_value_3 = axis_value[3];

    // actions without positions carry zero axes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action != ACT_STREAM && m_action != ACT_HOME) |->
        (m_axis_value_0 == '0 && m_axis_value_1 == '0
         && m_axis_value_2 == '0 && m_axis_value_3 == '0))
        else $error("axis values set on an action without positions");

    // stream position results carry the matching command byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_STREAM) |-> (m_command_byte == codes_reg.stream))
        else $error("stream action with a foreign command byte");

    // ignored results match none of the codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_IGNORED) |->
        (m_command_byte != codes_reg.stream && m_command_byte != codes_reg.rst
         && m_command_byte != codes_reg.home && m_command_byte != codes_reg.open
         && m_command_byte != codes_reg.close && m_command_byte != codes_reg.estop))
        else $error("known command decoded as ignored");

    // decoded action stays within the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_action <= ACT_ESTOP))
        else $error("undefined action code");

endmodule
`default_nettype wire

/* sv/sbcd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_front
// frame tracker: hunts for the start byte and tags each frame byte
// ----------------------------------------------------------------------------
module sbcd_front #(
    parameter int FRAME_BYTES = sbcd_pkg::FRAME_BYTES_DEF,
    parameter int AXES        = sbcd_pkg::AXES_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [sbcd_pkg::BYTE_W-1:0] s_rx_byte,
    input  wire  [sbcd_pkg::BYTE_W-1:0] start_code,
    output logic                       push_valid,
    output sbcd_pkg::tok_t             push_tok,
    input  wire                        push_ready
);
    import sbcd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_BYTES - 1);
    localparam logic [2:0]       AXES_C   = 3'(AXES);

    logic             in_frame_reg, in_frame_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] q;
    logic             take;

    assign s_ready = push_ready;
    assign take    = s_valid && push_ready;
    assign q       = idx_reg - IDX_W'(2);

    always_comb begin
        in_frame_next  = in_frame_reg;
        idx_next       = idx_reg;
        push_valid     = 1'b0;
        push_tok.kind  = TOK_DATA;
        push_tok.data  = s_rx_byte;
        push_tok.slot  = q[SLOT_W+LANE_W-1:LANE_W];
        push_tok.lane  = q[LANE_W-1:0];
        push_tok.store = ({1'b0, q[IDX_W-1:LANE_W]} < {1'b0, AXES_C});
        if (take) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == start_code) begin
                    in_frame_next = 1'b1;
                    idx_next      = IDX_W'(1);
                    push_valid    = 1'b1;
                    push_tok.kind = TOK_START;
                end
            end else if (idx_reg >= LAST_POS) begin
                in_frame_next = 1'b0;
                idx_next      = '0;
                push_valid    = 1'b1;
                push_tok.kind = TOK_CHECK;
            end else begin
                idx_next      = idx_reg + IDX_W'(1);
                push_valid    = 1'b1;
                push_tok.kind = (idx_reg <= IDX_W'(1)) ? TOK_CMD : TOK_DATA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            idx_reg      <= idx_next;
        end
    end

endmodule
`default_nettype wire

/* sv/sbcd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_queue
// two-entry token queue between front and back
// ----------------------------------------------------------------------------
module sbcd_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             in_valid,
    output logic            in_ready,
    input  sbcd_pkg::tok_t  in_tok,
    output logic            out_valid,
    input  wire             out_ready,
    output sbcd_pkg::tok_t  out_tok
);
    import sbcd_pkg::*;

    tok_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       wr_en, rd_en;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_tok   = slot_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 2'd1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule
`default_nettype wire

/* sv/sbcd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_back
// frame assembler: checksum, axis words, command decode and result register
// ----------------------------------------------------------------------------
module sbcd_back #(
    parameter int AXES = sbcd_pkg::AXES_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          tok_valid,
    output logic                         tok_ready,
    input  sbcd_pkg::tok_t               tok,
    input  sbcd_pkg::cmd_codes_t         codes,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [sbcd_pkg::ACTION_W-1:0] m_action,
    output logic [sbcd_pkg::BYTE_W-1:0]  m_command_byte,
    output logic signed [sbcd_pkg::AXIS_W-1:0] m_axis_value [sbcd_pkg::AXIS_SLOTS]
);
    import sbcd_pkg::*;

    logic [BYTE_W-1:0]   acc_reg, acc_next;
    logic [BYTE_W-1:0]   held_reg, held_next;
    logic [AXIS_W-1:0]   word_reg [AXIS_SLOTS];
    logic [AXIS_W-1:0]   word_next [AXIS_SLOTS];
    logic                out_valid_reg, out_valid_next;
    logic [ACTION_W-1:0] action_reg;
    logic [BYTE_W-1:0]   cmd_out_reg;
    logic [AXIS_W-1:0]   axis_out_reg [AXIS_SLOTS];
    logic [ACTION_W-1:0] act;
    logic                fire, emit, carries;

    // first matching code wins
    always_comb begin
        if (held_reg == codes.stream) begin
            act = ACT_STREAM;
        end else if (held_reg == codes.rst) begin
            act = ACT_RESET;
        end else if (held_reg == codes.home) begin
            act = ACT_HOME;
        end else if (held_reg == codes.open) begin
            act = ACT_OPEN;
        end else if (held_reg == codes.close) begin
            act = ACT_CLOSE;
        end else if (held_reg == codes.estop) begin
            act = ACT_ESTOP;
        end else begin
            act = ACT_IGNORED;
        end
    end

    assign carries   = (act == ACT_STREAM) || (act == ACT_HOME);
    assign tok_ready = !(tok.kind == TOK_CHECK && out_valid_reg && !m_ready);
    assign fire      = tok_valid && tok_ready;
    assign emit      = fire && (tok.kind == TOK_CHECK) && (tok.data == acc_reg);

    always_comb begin
        acc_next  = acc_reg;
        held_next = held_reg;
        for (int k = 0; k < AXIS_SLOTS; k++) begin
            word_next[k] = word_reg[k];
        end
        if (fire) begin
            case (tok.kind)
                TOK_START: begin
                    acc_next  = '0;
                    held_next = '0;
                    for (int k = 0; k < AXIS_SLOTS; k++) begin
                        word_next[k] = '0;
                    end
                end
                TOK_CMD: begin
                    acc_next  = acc_reg ^ tok.data;
                    held_next = tok.data;
                end
                TOK_DATA: begin
                    acc_next = acc_reg ^ tok.data;
                    for (int k = 0; k < AXIS_SLOTS; k++) begin
                        for (int l = 0; l < 4; l++) begin
                            if (tok.store && tok.slot == SLOT_W'(k)
                                    && tok.lane == LANE_W'(l)) begin
                                word_next[k][8*l +: 8] = word_reg[k][8*l +: 8] | tok.data;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        held_reg <= held_next;
        for (int k = 0; k < AXIS_SLOTS; k++) begin
            word_reg[k] <= word_next[k];
        end
        if (emit) begin
            action_reg  <= act;
            cmd_out_reg <= held_reg;
            for (int k = 0; k < AXIS_SLOTS; k++) begin
                axis_out_reg[k] <= (carries && k < AXES) ? word_reg[k] : '0;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_action       = action_reg;
    assign m_command_byte = cmd_out_reg;
    always_comb begin
        for (int k = 0; k < AXIS_SLOTS; k++) begin
            m_axis_value[k] = axis_out_reg[k];
        end
    end

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// drives framed rx beats into the start-byte command deframer and checks every
// decoded command against a local frame predictor or a hand-typed expectation,
// over several start and command code settings, with random stalls on both channels
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbcd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;      // the result is registered when the check beat is taken
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_BEATS  = 220;

    // one decoded command as the block reports it
    typedef struct packed {
        logic [ACTION_W-1:0]          action;
        logic [BYTE_W-1:0]            cmd;
        logic [AXIS_SLOTS-1:0][AXIS_W-1:0] axes;
    } cmd_result_t;

    // one rx beat, with an optional hand-typed expectation on the check beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic              t_has;
        cmd_result_t       t_res;
    } rx_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_rx_byte = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [ACTION_W-1:0]   m_action;
    logic [BYTE_W-1:0]     m_command_byte;
    logic signed [AXIS_W-1:0] m_axis_value_0;
    logic signed [AXIS_W-1:0] m_axis_value_1;
    logic signed [AXIS_W-1:0] m_axis_value_2;
    logic signed [AXIS_W-1:0] m_axis_value_3;

    sync_byte_command_deframer_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_command_byte (m_command_byte),
        .m_axis_value_0 (m_axis_value_0),
        .m_axis_value_1 (m_axis_value_1),
        .m_axis_value_2 (m_axis_value_2),
        .m_axis_value_3 (m_axis_value_3)
    );

    // 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // frame predictor: own copy of registers and deframer state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] cfg_regs [0:6];
    logic              frm_active;
    logic [IDX_W-1:0]  frm_pos;
    logic [BYTE_W-1:0] frm_xor;
    logic [BYTE_W-1:0] frm_cmd;
    logic [AXIS_W-1:0] frm_axis [0:AXIS_SLOTS-1];

    function automatic void deframer_reset();
        cfg_regs[REG_START_CODE]  = RST_START_CODE;
        cfg_regs[REG_CODE_STREAM] = RST_CODE_STREAM;
        cfg_regs[REG_CODE_RESET]  = RST_CODE_RESET;
        cfg_regs[REG_CODE_HOME]   = RST_CODE_HOME;
        cfg_regs[REG_CODE_OPEN]   = RST_CODE_OPEN;
        cfg_regs[REG_CODE_CLOSE]  = RST_CODE_CLOSE;
        cfg_regs[REG_CODE_ESTOP]  = RST_CODE_ESTOP;
        frm_active = 1'b0;
        frm_pos    = '0;
        frm_xor    = '0;
        frm_cmd    = '0;
        for (int k = 0; k < AXIS_SLOTS; k++) frm_axis[k] = '0;
    endfunction

    // first matching code wins, in stream/reset/home/open/close/estop order
    function automatic logic [ACTION_W-1:0] decode_cmd(input logic [BYTE_W-1:0] c);
        if (c == cfg_regs[REG_CODE_STREAM]) return ACT_STREAM;
        if (c == cfg_regs[REG_CODE_RESET])  return ACT_RESET;
        if (c == cfg_regs[REG_CODE_HOME])   return ACT_HOME;
        if (c == cfg_regs[REG_CODE_OPEN])   return ACT_OPEN;
        if (c == cfg_regs[REG_CODE_CLOSE])  return ACT_CLOSE;
        if (c == cfg_regs[REG_CODE_ESTOP])  return ACT_ESTOP;
        return ACT_IGNORED;
    endfunction

    // advance the predictor by one rx beat; returns 1 when a command comes out
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output cmd_result_t r);
        int unsigned pos;
        int unsigned q;
        int unsigned axis;
        bit          carries;
        r = '0;
        if (!frm_active) begin
            // start code is only looked at while hunting
            if (b == cfg_regs[REG_START_CODE]) begin
                frm_active = 1'b1;
                frm_pos    = 5'd1;
                frm_xor    = '0;
                frm_cmd    = '0;
                for (int k = 0; k < AXIS_SLOTS; k++) frm_axis[k] = '0;
            end
            return 1'b0;
        end
        pos = frm_pos;
        if (pos >= FRAME_BYTES_DEF - 1) begin
            // check beat, good or bad we go back to hunting
            frm_active = 1'b0;
            frm_pos    = '0;
            if (b != frm_xor) return 1'b0;
            r.action = decode_cmd(frm_cmd);
            r.cmd    = frm_cmd;
            carries  = (r.action == ACT_STREAM) || (r.action == ACT_HOME);
            for (int k = 0; k < AXIS_SLOTS; k++)
                r.axes[k] = (carries && k < AXES_DEF) ? frm_axis[k] : '0;
            return 1'b1;
        end
        frm_xor = frm_xor ^ b;
        if (pos <= 1) begin
            frm_cmd = b;
        end else begin
            q    = pos - 2;
            axis = q >> 2;
            if (axis < AXES_DEF && axis < AXIS_SLOTS)
                frm_axis[axis] = frm_axis[axis] | (AXIS_W'(b) << ((q & 3) * 8));
        end
        frm_pos = IDX_W'(pos + 1);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // shared stores
    // ------------------------------------------------------------------
    rx_beat_t    rx_beats [$];       // beats waiting to be offered
    rx_beat_t    frame_beats [$];    // scratch for the frame being built
    rx_beat_t    held_beats [$];     // tail of a frame split across a setting change
    cmd_result_t pending_cmds [$];   // decoded commands still to arrive

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  send_idle   = 1'b0;
    bit  recv_idle   = 1'b0;
    bit  hold_req    = 1'b0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // rx side: offer beats, predict on every accepted beat
    // ------------------------------------------------------------------
    rx_beat_t cur_beat;
    int       send_gap = 0;

    always @(posedge aclk) begin : rx_driver
        cmd_result_t res;
        bit          got;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                got = deframe_byte(cur_beat.data, res);
                if (cur_beat.typed) begin
                    if (cur_beat.t_has) pending_cmds.push_back(cur_beat.t_res);
                end else if (got) begin
                    pending_cmds.push_back(res);
                end
            end
            // only move on once the offered beat is gone
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (rx_beats.size() > 0) begin
                    cur_beat = rx_beats.pop_front();
                    s_valid   <= 1'b1;
                    s_rx_byte <= cur_beat.data;
                    send_gap  = send_idle ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // command side: random ready, long hold-off on request, compare
    // ------------------------------------------------------------------
    int recv_gap  = 0;
    int hold_left = 0;

    task automatic note_fail(input string what, input cmd_result_t e);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("mismatch (%s): exp act=%0d cmd=%02h ax=%0d %0d %0d %0d, got act=%0d cmd=%02h ax=%0d %0d %0d %0d",
                     what, e.action, e.cmd, $signed(e.axes[0]), $signed(e.axes[1]),
                     $signed(e.axes[2]), $signed(e.axes[3]), m_action, m_command_byte,
                     m_axis_value_0, m_axis_value_1, m_axis_value_2, m_axis_value_3);
    endtask

    task automatic check_cmd();
        cmd_result_t e;
        if (pending_cmds.size() == 0) begin
            note_fail("no command pending", '0);
        end else begin
            e = pending_cmds.pop_front();
            if (m_action !== e.action || m_command_byte !== e.cmd ||
                m_axis_value_0 !== e.axes[0] || m_axis_value_1 !== e.axes[1] ||
                m_axis_value_2 !== e.axes[2] || m_axis_value_3 !== e.axes[3])
                note_fail("field", e);
        end
    endtask

    always @(posedge aclk) begin : cmd_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_cmd();
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = recv_idle ? pick_gap() : 0;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic rx_beat_t plain_beat(input logic [BYTE_W-1:0] d);
        rx_beat_t b;
        b      = '0;
        b.data = d;
        return b;
    endfunction

    // start, command, little-endian axis bytes, xor check; bad flips the check
    task automatic build_frame(input logic [BYTE_W-1:0] cmd,
                               input logic [AXIS_SLOTS-1:0][AXIS_W-1:0] ax,
                               input bit bad, input bit typed,
                               input logic [ACTION_W-1:0] t_act, input bit t_carry);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] d;
        rx_beat_t          chk;
        int                axis;
        frame_beats.delete();
        frame_beats.push_back(plain_beat(cfg_regs[REG_START_CODE]));
        frame_beats.push_back(plain_beat(cmd));
        sum = cmd;
        for (int p = 0; p < FRAME_BYTES_DEF - 3; p++) begin
            axis = p >> 2;
            d    = (axis < AXIS_SLOTS) ? ax[axis][(p & 3) * 8 +: 8] : BYTE_W'($urandom);
            sum  = sum ^ d;
            frame_beats.push_back(plain_beat(d));
        end
        if (bad) sum = sum ^ BYTE_W'($urandom_range(1, 255));
        chk              = plain_beat(sum);
        chk.typed        = typed;
        chk.t_has        = !bad;
        chk.t_res.action = t_act;
        chk.t_res.cmd    = cmd;
        chk.t_res.axes   = t_carry ? ax : '0;
        frame_beats.push_back(chk);
    endtask

    task automatic move_beats(input int n);
        for (int i = 0; i < n && frame_beats.size() > 0; i++)
            rx_beats.push_back(frame_beats.pop_front());
    endtask

    // one row of the directed table: noise bytes ahead, then one frame
    task automatic dir_row(input int lead, input logic [BYTE_W-1:0] cmd,
                           input logic [AXIS_W-1:0] a0, input logic [AXIS_W-1:0] a1,
                           input logic [AXIS_W-1:0] a2, input logic [AXIS_W-1:0] a3,
                           input bit bad, input bit typed,
                           input logic [ACTION_W-1:0] t_act, input bit t_carry);
        logic [BYTE_W-1:0] n;
        for (int i = 0; i < lead; i++) begin
            n = BYTE_W'($urandom);
            if (n == cfg_regs[REG_START_CODE]) n = n ^ 8'h01;
            rx_beats.push_back(plain_beat(n));
        end
        build_frame(cmd, {a3, a2, a1, a0}, bad, typed, t_act, t_carry);
        move_beats(frame_beats.size());
    endtask

    // block idle: all beats in, all commands out, pipeline drained
    task automatic wait_idle();
        while (rx_beats.size() != 0 || s_valid) @(negedge aclk);
        while (pending_cmds.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        cfg_regs[idx] = v;
    endtask

    task automatic write_all(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] sp,
                             input logic [BYTE_W-1:0] rs, input logic [BYTE_W-1:0] hm,
                             input logic [BYTE_W-1:0] op, input logic [BYTE_W-1:0] cl,
                             input logic [BYTE_W-1:0] es);
        write_reg(REG_START_CODE,  st);
        write_reg(REG_CODE_STREAM, sp);
        write_reg(REG_CODE_RESET,  rs);
        write_reg(REG_CODE_HOME,   hm);
        write_reg(REG_CODE_OPEN,   op);
        write_reg(REG_CODE_CLOSE,  cl);
        write_reg(REG_CODE_ESTOP,  es);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [AXIS_W-1:0] rand_axis();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return AXIS_W'($urandom);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        // start byte as payload data
        if (r < 87) return {4{cfg_regs[REG_START_CODE]}};
        return AXIS_W'($urandom_range(0, 200)) - 32'd100;
    endfunction

    // random phase: mostly good frames, some bad checks, cut frames, noise
    task automatic run_phase(input int budget, input bit idle_s, input bit idle_r,
                             input bit hold, input bit split);
        int                               sent;
        int                               r;
        int                               cut;
        logic [BYTE_W-1:0]                cmd;
        logic [AXIS_SLOTS-1:0][AXIS_W-1:0] ax;
        send_idle = idle_s;
        recv_idle = idle_r;
        if (hold) hold_req = 1'b1;
        // tail of a frame left open across the setting change
        while (held_beats.size() > 0) rx_beats.push_back(held_beats.pop_front());
        sent = 0;
        while (sent < budget) begin
            r   = $urandom_range(0, 99);
            cmd = ($urandom_range(0, 3) != 0) ? cfg_regs[$urandom_range(1, 6)]
                                              : BYTE_W'($urandom);
            for (int k = 0; k < AXIS_SLOTS; k++) ax[k] = rand_axis();
            if (r < 72) begin
                build_frame(cmd, ax, 1'b0, 1'b0, ACT_IGNORED, 1'b0);
                sent += frame_beats.size();
                move_beats(frame_beats.size());
            end else if (r < 84) begin
                build_frame(cmd, ax, 1'b1, 1'b0, ACT_IGNORED, 1'b0);
                sent += frame_beats.size();
                move_beats(frame_beats.size());
            end else if (r < 92) begin
                // cut frame: what follows is swallowed as frame data
                build_frame(cmd, ax, 1'b0, 1'b0, ACT_IGNORED, 1'b0);
                cut = $urandom_range(1, FRAME_BYTES_DEF - 1);
                sent += cut;
                move_beats(cut);
            end else begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    rx_beats.push_back(plain_beat(BYTE_W'($urandom)));
            end
        end
        if (split) begin
            build_frame(cfg_regs[$urandom_range(1, 6)], {rand_axis(), rand_axis(),
                        rand_axis(), rand_axis()}, 1'b0, 1'b0, ACT_IGNORED, 1'b0);
            move_beats($urandom_range(2, FRAME_BYTES_DEF - 2));
            while (frame_beats.size() > 0) held_beats.push_back(frame_beats.pop_front());
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        deframer_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows at reset settings
        send_idle = 1'b1;
        recv_idle = 1'b1;
        //      lead cmd    axis 0        axis 1        axis 2        axis 3       bad typ action  carry
        dir_row(0, 8'h01, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00000000, 0, 1, ACT_STREAM, 1);
        dir_row(3, 8'h02, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0, 0, 1, ACT_RESET, 0);
        dir_row(0, 8'h03, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 1, ACT_HOME, 1);
        dir_row(1, 8'h04, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1, ACT_OPEN, 0);
        dir_row(0, 8'h05, 32'h00000001, 32'h00000002, 32'h00000003, 32'h00000004, 0, 1, ACT_CLOSE, 0);
        dir_row(2, 8'h06, 32'hDEADBEEF, 32'h01020304, 32'h7FFFFFFF, 32'h80000000, 0, 1, ACT_ESTOP, 0);
        dir_row(0, 8'hFF, 32'h11111111, 32'h22222222, 32'h33333333, 32'h44444444, 0, 1, ACT_IGNORED, 0);
        dir_row(0, 8'h00, 32'h55555555, 32'h66666666, 32'h77777777, 32'h88888888, 0, 1, ACT_IGNORED, 0);
        dir_row(0, 8'h01, 32'h01234567, 32'h89ABCDEF, 32'h00000000, 32'hFFFFFFFF, 1, 1, ACT_IGNORED, 0);
        // start byte inside the payload is plain data
        dir_row(0, 8'h01, 32'hAAAAAAAA, 32'h00AA00AA, 32'hAA000000, 32'h000000AA, 0, 1, ACT_STREAM, 1);
        dir_row(0, 8'hAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 0, 1, ACT_IGNORED, 0);
        dir_row(4, 8'h03, rand_axis(), rand_axis(), rand_axis(), rand_axis(), 0, 0, ACT_IGNORED, 0);
        dir_row(0, 8'h01, rand_axis(), rand_axis(), rand_axis(), rand_axis(), 0, 0, ACT_IGNORED, 0);
        wait_idle();

        // overlapping codes: first match in decode order wins
        write_all(8'h00, 8'h11, 8'h22, 8'h22, 8'h33, 8'hFF, 8'h11);
        dir_row(2, 8'h11, 32'h7FFFFFFF, 32'h00000000, 32'h80000000, 32'h00000001, 0, 1, ACT_STREAM, 1);
        dir_row(0, 8'h22, 32'h12345678, 32'h12345678, 32'h12345678, 32'h12345678, 0, 1, ACT_RESET, 0);
        dir_row(0, 8'h33, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 0, 1, ACT_OPEN, 0);
        dir_row(1, 8'hFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 0, 1, ACT_CLOSE, 0);
        wait_idle();

        // random phases over several settings, frames left open across changes
        write_all(RST_START_CODE, RST_CODE_STREAM, RST_CODE_RESET, RST_CODE_HOME,
                  RST_CODE_OPEN, RST_CODE_CLOSE, RST_CODE_ESTOP);
        run_phase(PHASE_BEATS, 1'b1, 1'b1, 1'b0, 1'b1);

        // all at the top value, no idling on either side
        write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_phase(PHASE_BEATS, 1'b0, 1'b0, 1'b0, 1'b1);

        // all zero, with the long receiver hold-off so the block backs up
        write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_phase(PHASE_BEATS, 1'b0, 1'b1, 1'b1, 1'b1);

        write_all(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        run_phase(PHASE_BEATS, 1'b1, 1'b1, 1'b0, 1'b1);

        write_all(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        run_phase(PHASE_BEATS, 1'b1, 1'b0, 1'b1, 1'b1);

        // few distinct codes so overlaps come up at random
        write_all(8'h5A, 8'h81, $urandom_range(0, 1) ? 8'h81 : 8'h7E, 8'h7E,
                  8'h7E, $urandom_range(0, 1) ? 8'h81 : 8'h42, 8'h42);
        run_phase(PHASE_BEATS, 1'b1, 1'b1, 1'b0, 1'b0);

        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
